[rtl/core/segment_intersection_cramer_macros.svh]
// assertion macros for the segment intersection rtl
`ifndef SEGMENT_INTERSECTION_CRAMER_MACROS_SVH
`define SEGMENT_INTERSECTION_CRAMER_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SIC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent that must hold in the clock cycle after the antecedent
`define SIC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/sic_pkg.sv]
// shared types and constants for the segment intersection block
package sic_pkg;

   // port widths fixed by the interface
   localparam int FIELD_W    = 32;
   localparam int THR_W      = 21;
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 2;

   // register map
   localparam logic [APB_ADDR_W-1:0] ADDR_PARALLEL_THRESHOLD = 2'd0;

   // threshold after reset
   localparam logic [THR_W-1:0] THR_RESET = 21'd1;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_HIT      = 2'd0,
      STATUS_PARALLEL = 2'd1,
      STATUS_MISS     = 2'd2
   } status_type;

endpackage

[rtl/core/sic_div.sv]
// pipelined restoring divider, one quotient bit per stage, with the final offset add
module sic_div #(
   parameter int W = 32
) (
   input  logic                 clock,
   input  logic [3*W:0]         num,
   input  logic [2*W:0]         den,
   input  logic                 neg,
   input  logic [W-1:0]         base,
   output logic [W-1:0]         result
);

   localparam int MW = 2 * W + 1;
   localparam int NW = 3 * W + 1;

   // per-stage pipeline registers
   logic [MW-1:0] rem_ff  [W];
   logic [MW-1:0] rem_in  [W];
   logic [W-1:0]  low_ff  [W];
   logic [W-1:0]  low_in  [W];
   logic [W-1:0]  quo_ff  [W];
   logic [W-1:0]  quo_in  [W];
   logic [MW-1:0] den_ff  [W];
   logic [MW-1:0] den_in  [W];
   logic          neg_ff  [W];
   logic          neg_in  [W];
   logic [W-1:0]  base_ff [W];
   logic [W-1:0]  base_in [W];
   logic [W-1:0]  result_ff;
   logic [W-1:0]  result_in;

   // trial subtract in each stage; high numerator part already below den
   always_comb begin
      logic [MW-1:0] rem_prev;
      logic [W-1:0]  low_prev;
      logic [W-1:0]  quo_prev;
      logic [MW-1:0] den_prev;
      logic          neg_prev;
      logic [W-1:0]  base_prev;
      logic [MW:0]   trial;
      logic [MW+1:0] diff;
      logic          take;
      for (int i = 0; i < W; i++) begin
         if (i == 0) begin
            rem_prev  = num[NW-1:W];
            low_prev  = num[W-1:0];
            quo_prev  = '0;
            den_prev  = den;
            neg_prev  = neg;
            base_prev = base;
         end else begin
            rem_prev  = rem_ff[i-1];
            low_prev  = low_ff[i-1];
            quo_prev  = quo_ff[i-1];
            den_prev  = den_ff[i-1];
            neg_prev  = neg_ff[i-1];
            base_prev = base_ff[i-1];
         end
         trial      = {rem_prev, low_prev[W-1]};
         diff       = {1'b0, trial} - {2'b00, den_prev};
         take       = ~diff[MW+1];
         rem_in[i]  = take ? diff[MW-1:0] : trial[MW-1:0];
         low_in[i]  = {low_prev[W-2:0], 1'b0};
         quo_in[i]  = {quo_prev[W-2:0], take};
         den_in[i]  = den_prev;
         neg_in[i]  = neg_prev;
         base_in[i] = base_prev;
      end
   end

   // apply the sign of the quotient to the start coordinate
   always_comb begin
      if (neg_ff[W-1]) begin
         result_in = base_ff[W-1] - quo_ff[W-1];
      end else begin
         result_in = base_ff[W-1] + quo_ff[W-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < W; i++) begin
         rem_ff[i]  <= rem_in[i];
         low_ff[i]  <= low_in[i];
         quo_ff[i]  <= quo_in[i];
         den_ff[i]  <= den_in[i];
         neg_ff[i]  <= neg_in[i];
         base_ff[i] <= base_in[i];
      end
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

[rtl/core/segment_intersection_cramer.sv]
// top level: segment pair intersection by exact cramer determinants
//
// Fully pipelined: one transaction may be started in every cycle and busy stays
// low. Each transaction returns exactly one result, strobed by rsp_valid for one
// cycle. The depth is set by the crossing point divider, which resolves one
// quotient bit per stage and adds the start coordinate in one more stage; six
// stages ahead of it form the differences, the products, the determinants, the
// classification, the partial products and the numerator, and one register
// holds the result. The receiver must take every result in the cycle it is shown.
// parallel_threshold sits at byte address 0 and may only be written while no
// transaction is in flight.
module segment_intersection_cramer
   import sic_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // transaction input
   input  logic                  start,
   output logic                  busy,
   input  logic [FIELD_W-1:0]    req_a_start_x,
   input  logic [FIELD_W-1:0]    req_a_start_y,
   input  logic [FIELD_W-1:0]    req_a_end_x,
   input  logic [FIELD_W-1:0]    req_a_end_y,
   input  logic [FIELD_W-1:0]    req_b_start_x,
   input  logic [FIELD_W-1:0]    req_b_start_y,
   input  logic [FIELD_W-1:0]    req_b_end_x,
   input  logic [FIELD_W-1:0]    req_b_end_y,
   // result output
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [FIELD_W-1:0]    rsp_cross_x,
   output logic [FIELD_W-1:0]    rsp_cross_y,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready
);

   `include "segment_intersection_cramer_macros.svh"

   localparam int CB  = COORD_BITS;
   localparam int DFW = CB + 1;       // coordinate difference
   localparam int PW  = 2 * CB + 2;   // products and determinants
   localparam int MW  = 2 * CB + 1;   // determinant magnitude
   localparam int PLW = 2 * CB;       // low partial product
   localparam int PHW = 2 * CB + 1;   // high partial product
   localparam int NW  = 3 * CB + 1;   // divider numerator
   localparam int CW  = PW + THR_W;   // threshold compare
   localparam int LAT = CB + 8;       // start to result

   // ---------------------------------------------------------------- registers
   logic [THR_W-1:0] thr_ff;
   logic [THR_W-1:0] thr_in;
   logic             csr_write;

   // register write and read
   always_comb begin
      csr_write = psel & penable & pwrite & pready & (paddr == ADDR_PARALLEL_THRESHOLD);
      thr_in    = csr_write ? pwdata[THR_W-1:0] : thr_ff;
      prdata    = (paddr == ADDR_PARALLEL_THRESHOLD) ? APB_DATA_W'(thr_ff) : '0;
   end

   assign pready = 1'b1;
   assign busy   = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // ---------------------------------------------------------------- control
   logic       vld_ff [1:LAT];
   status_type sts_ff [4:LAT-1];
   status_type sts_in;

   // valid bits and status travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[1] <= start & ~busy;
         for (int k = 2; k <= LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      sts_ff[4] <= sts_in;
      for (int k = 5; k < LAT; k++) begin
         sts_ff[k] <= sts_ff[k-1];
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic signed [DFW-1:0] a1x_w, a1y_w, a2x_w, a2y_w, b1x_w, b1y_w, b2x_w, b2y_w;
   logic signed [DFW-1:0] dax_ff, day_ff, bdx_ff, bdy_ff, abx_ff, aby_ff, ex1_ff, ey1_ff;
   logic signed [DFW-1:0] dax_in, day_in, bdx_in, bdy_in, abx_in, aby_in, ex1_in, ey1_in;
   logic [CB-1:0]         bx1_ff, by1_ff, bx1_in, by1_in;

   // coordinate differences from the low COORD_BITS of each field
   always_comb begin
      a1x_w  = DFW'($signed(req_a_start_x[CB-1:0]));
      a1y_w  = DFW'($signed(req_a_start_y[CB-1:0]));
      a2x_w  = DFW'($signed(req_a_end_x[CB-1:0]));
      a2y_w  = DFW'($signed(req_a_end_y[CB-1:0]));
      b1x_w  = DFW'($signed(req_b_start_x[CB-1:0]));
      b1y_w  = DFW'($signed(req_b_start_y[CB-1:0]));
      b2x_w  = DFW'($signed(req_b_end_x[CB-1:0]));
      b2y_w  = DFW'($signed(req_b_end_y[CB-1:0]));
      dax_in = a1x_w - a2x_w;
      day_in = a1y_w - a2y_w;
      bdx_in = b2x_w - b1x_w;
      bdy_in = b2y_w - b1y_w;
      abx_in = a1x_w - b1x_w;
      aby_in = a1y_w - b1y_w;
      ex1_in = a2x_w - a1x_w;
      ey1_in = a2y_w - a1y_w;
      bx1_in = req_a_start_x[CB-1:0];
      by1_in = req_a_start_y[CB-1:0];
   end

   always_ff @(posedge clock) begin
      dax_ff <= dax_in;
      day_ff <= day_in;
      bdx_ff <= bdx_in;
      bdy_ff <= bdy_in;
      abx_ff <= abx_in;
      aby_ff <= aby_in;
      ex1_ff <= ex1_in;
      ey1_ff <= ey1_in;
      bx1_ff <= bx1_in;
      by1_ff <= by1_in;
   end

   // ---------------------------------------------------------------- stage 2
   logic signed [PW-1:0]  pd0_ff, pd1_ff, pa0_ff, pa1_ff, pb0_ff, pb1_ff;
   logic signed [PW-1:0]  pd0_in, pd1_in, pa0_in, pa1_in, pb0_in, pb1_in;
   logic signed [DFW-1:0] ex2_ff, ey2_ff;
   logic [CB-1:0]         bx2_ff, by2_ff;

   // the six cross products
   always_comb begin
      pd0_in = PW'(dax_ff) * PW'(bdy_ff);
      pd1_in = PW'(day_ff) * PW'(bdx_ff);
      pa0_in = PW'(abx_ff) * PW'(bdy_ff);
      pa1_in = PW'(aby_ff) * PW'(bdx_ff);
      pb0_in = PW'(dax_ff) * PW'(aby_ff);
      pb1_in = PW'(day_ff) * PW'(abx_ff);
   end

   always_ff @(posedge clock) begin
      pd0_ff <= pd0_in;
      pd1_ff <= pd1_in;
      pa0_ff <= pa0_in;
      pa1_ff <= pa1_in;
      pb0_ff <= pb0_in;
      pb1_ff <= pb1_in;
      ex2_ff <= ex1_ff;
      ey2_ff <= ey1_ff;
      bx2_ff <= bx1_ff;
      by2_ff <= by1_ff;
   end

   // ---------------------------------------------------------------- stage 3
   logic signed [PW-1:0]  d_ff, da_ff, db_ff, d_in, da_in, db_in;
   logic signed [DFW-1:0] ex3_ff, ey3_ff;
   logic [CB-1:0]         bx3_ff, by3_ff;

   // determinants d, da and db
   always_comb begin
      d_in  = pd0_ff - pd1_ff;
      da_in = pa0_ff - pa1_ff;
      db_in = pb0_ff - pb1_ff;
   end

   always_ff @(posedge clock) begin
      d_ff   <= d_in;
      da_ff  <= da_in;
      db_ff  <= db_in;
      ex3_ff <= ex2_ff;
      ey3_ff <= ey2_ff;
      bx3_ff <= bx2_ff;
      by3_ff <= by2_ff;
   end

   // ---------------------------------------------------------------- stage 4
   logic signed [CW-1:0] d_big, thr_big;
   logic                 d_neg, da_neg, db_neg, big_enough, hit;
   logic [MW-1:0]        dmag4_ff, damag4_ff, dmag4_in, damag4_in;
   logic [CB-1:0]        exmag4_ff, eymag4_ff, exmag4_in, eymag4_in;
   logic                 negx4_ff, negy4_ff, negx4_in, negy4_in;
   logic [CB-1:0]        bx4_ff, by4_ff;

   // parallel test, range test of both parameters and magnitudes for the quotient
   always_comb begin
      d_neg      = d_ff[PW-1];
      da_neg     = da_ff[PW-1];
      db_neg     = db_ff[PW-1];
      d_big      = CW'(d_ff);
      thr_big    = CW'($signed({1'b0, thr_ff}));
      big_enough = (d_big >= thr_big) || (d_big <= -thr_big);
      if (!d_neg) begin
         hit = !da_neg && (da_ff <= d_ff) && !db_neg && (db_ff <= d_ff);
      end else begin
         hit = (da_neg || (da_ff == '0)) && (da_ff >= d_ff)
            && (db_neg || (db_ff == '0)) && (db_ff >= d_ff);
      end
      if ((d_ff == '0) || !big_enough) begin
         sts_in = STATUS_PARALLEL;
      end else if (hit) begin
         sts_in = STATUS_HIT;
      end else begin
         sts_in = STATUS_MISS;
      end
      dmag4_in  = d_neg ? MW'(-d_ff) : MW'(d_ff);
      damag4_in = da_neg ? MW'(-da_ff) : MW'(da_ff);
      exmag4_in = ex3_ff[DFW-1] ? CB'(-ex3_ff) : CB'(ex3_ff);
      eymag4_in = ey3_ff[DFW-1] ? CB'(-ey3_ff) : CB'(ey3_ff);
      negx4_in  = da_neg ^ ex3_ff[DFW-1] ^ d_neg;
      negy4_in  = da_neg ^ ey3_ff[DFW-1] ^ d_neg;
   end

   always_ff @(posedge clock) begin
      dmag4_ff  <= dmag4_in;
      damag4_ff <= damag4_in;
      exmag4_ff <= exmag4_in;
      eymag4_ff <= eymag4_in;
      negx4_ff  <= negx4_in;
      negy4_ff  <= negy4_in;
      bx4_ff    <= bx3_ff;
      by4_ff    <= by3_ff;
   end

   // ---------------------------------------------------------------- stage 5
   logic [PLW-1:0] plx_ff, ply_ff, plx_in, ply_in;
   logic [PHW-1:0] phx_ff, phy_ff, phx_in, phy_in;
   logic [MW-1:0]  dmag5_ff;
   logic           negx5_ff, negy5_ff;
   logic [CB-1:0]  bx5_ff, by5_ff;

   // |da| times |delta| as two partial products per coordinate
   always_comb begin
      plx_in = PLW'(damag4_ff[CB-1:0]) * PLW'(exmag4_ff);
      ply_in = PLW'(damag4_ff[CB-1:0]) * PLW'(eymag4_ff);
      phx_in = PHW'(damag4_ff[MW-1:CB]) * PHW'(exmag4_ff);
      phy_in = PHW'(damag4_ff[MW-1:CB]) * PHW'(eymag4_ff);
   end

   always_ff @(posedge clock) begin
      plx_ff   <= plx_in;
      ply_ff   <= ply_in;
      phx_ff   <= phx_in;
      phy_ff   <= phy_in;
      dmag5_ff <= dmag4_ff;
      negx5_ff <= negx4_ff;
      negy5_ff <= negy4_ff;
      bx5_ff   <= bx4_ff;
      by5_ff   <= by4_ff;
   end

   // ---------------------------------------------------------------- stage 6
   logic [NW-1:0] numx_ff, numy_ff, numx_in, numy_in;
   logic [MW-1:0] dmag6_ff;
   logic          negx6_ff, negy6_ff;
   logic [CB-1:0] bx6_ff, by6_ff;

   // combine partial products into the divider numerators
   always_comb begin
      numx_in = {phx_ff, {CB{1'b0}}} + NW'(plx_ff);
      numy_in = {phy_ff, {CB{1'b0}}} + NW'(ply_ff);
   end

   always_ff @(posedge clock) begin
      numx_ff  <= numx_in;
      numy_ff  <= numy_in;
      dmag6_ff <= dmag5_ff;
      negx6_ff <= negx5_ff;
      negy6_ff <= negy5_ff;
      bx6_ff   <= bx5_ff;
      by6_ff   <= by5_ff;
   end

   // ---------------------------------------------------------------- dividers
   logic [CB-1:0] div_x, div_y;

   sic_div #(
      .W (CB)
   ) u_div_x (
      .clock  (clock),
      .num    (numx_ff),
      .den    (dmag6_ff),
      .neg    (negx6_ff),
      .base   (bx6_ff),
      .result (div_x)
   );

   sic_div #(
      .W (CB)
   ) u_div_y (
      .clock  (clock),
      .num    (numy_ff),
      .den    (dmag6_ff),
      .neg    (negy6_ff),
      .base   (by6_ff),
      .result (div_y)
   );

   // ---------------------------------------------------------------- result
   status_type          rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0]  rsp_cross_x_ff, rsp_cross_y_ff, rsp_cross_x_in, rsp_cross_y_in;

   // crossing point only on a hit, zero otherwise
   always_comb begin
      rsp_status_in = sts_ff[LAT-1];
      if (sts_ff[LAT-1] == STATUS_HIT) begin
         rsp_cross_x_in = FIELD_W'($signed(div_x));
         rsp_cross_y_in = FIELD_W'($signed(div_y));
      end else begin
         rsp_cross_x_in = '0;
         rsp_cross_y_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_cross_x_ff <= rsp_cross_x_in;
      rsp_cross_y_ff <= rsp_cross_y_in;
   end

   assign rsp_valid   = vld_ff[LAT];
   assign rsp_status  = rsp_status_ff;
   assign rsp_cross_x = rsp_cross_x_ff;
   assign rsp_cross_y = rsp_cross_y_ff;

   // ---------------------------------------------------------------- checks
   `SIC_ASSERT(a_result_follows_start, (start && !busy) |-> ##LAT rsp_valid, "result missing after start")
   `SIC_ASSERT(a_result_has_start, rsp_valid |-> $past(start && !busy, LAT), "result without a start")
   `SIC_ASSERT(a_miss_zero_point, (rsp_valid && (rsp_status != STATUS_HIT)) |-> ((rsp_cross_x == '0) && (rsp_cross_y == '0)), "crossing point not cleared on a miss")
   `SIC_ASSERT_NEXT(a_thr_holds, !csr_write, $stable(thr_ff), "threshold changed without a write")

endmodule
